>>> rtl/core/jdc_pkg.sv
package jdc_pkg;

    // Reset value of the cutover register: first Gregorian day number
    localparam int CUTOVER_RESET = 2299161;

    // alpha = floor((4*Z - 7468865) / 146097), biased by 52 divisors so the
    // numerator never goes negative: alpha = floor((4*Z + 128179) / 146097) - 52
    localparam int ALPHA_BIAS = 128179;
    localparam int ALPHA_DIV  = 146097;

    // B = Z + 1524 (Julian), B = Z + q - floor(q/4) + 1486 (Gregorian, biased q)
    localparam int JULIAN_B_OFFSET = 1524;
    localparam int GREG_B_OFFSET   = 1486;

    // C = floor((20*B - 2442) / 7305)
    localparam int C_SCALE = 20;
    localparam int C_BIAS  = 2442;
    localparam int C_DIV   = 7305;

    // D = floor(1461*C / 4)
    localparam int D_MUL = 1461;

    // Day within the shifted year (B - D) always fits in 9 bits
    localparam int BD_W  = 9;
    localparam int E_MAX = 15;

    // Month and year from E
    localparam int E_WRAP          = 14;
    localparam int E_MONTH_EARLY   = 1;
    localparam int E_MONTH_LATE    = 13;
    localparam int MONTH_FEB       = 2;
    localparam int YEAR_BIAS_LATE  = 4716;
    localparam int YEAR_BIAS_EARLY = 4715;

    // 86400 = 675 * 2^7
    localparam int SEC_SCALE      = 675;
    localparam int SEC_SCALE_LOG2 = 7;
    localparam int SECS_W         = 17;
    localparam int DAY_SECS_MAX   = 86399;
    localparam int SECS_PER_HOUR  = 3600;
    localparam int HOUR_W         = 5;
    localparam int HOUR_REM_W     = 12;
    localparam int SECS_PER_MIN   = 60;
    localparam int MIN_W          = 6;
    localparam int SEC_W          = 6;

    // Cycles from an accepted start to its done strobe
    localparam int LATENCY = 11;

    typedef logic [BD_W-1:0] day_off_t;

    // floor(30.6001 * e)
    function automatic day_off_t month_base(input logic [3:0] e);
        day_off_t base;
        case (e)
            4'd1:    base = day_off_t'(30);
            4'd2:    base = day_off_t'(61);
            4'd3:    base = day_off_t'(91);
            4'd4:    base = day_off_t'(122);
            4'd5:    base = day_off_t'(153);
            4'd6:    base = day_off_t'(183);
            4'd7:    base = day_off_t'(214);
            4'd8:    base = day_off_t'(244);
            4'd9:    base = day_off_t'(275);
            4'd10:   base = day_off_t'(306);
            4'd11:   base = day_off_t'(336);
            4'd12:   base = day_off_t'(367);
            4'd13:   base = day_off_t'(397);
            4'd14:   base = day_off_t'(428);
            4'd15:   base = day_off_t'(459);
            default: base = '0;
        endcase
        return base;
    endfunction

endpackage

>>> rtl/core/julian_date_to_calendar.sv
// Channel   Direction  Signals                                   Beat taken when
// -------   ---------  ----------------------------------------  ------------------------
// request   in         start, busy, julian_date_fixed            start && !busy
// result    out        done, cal_year .. clock_second            done (one cycle, no hold)
// config    in         cfg_valid, cfg_ready, cfg_data            cfg_valid && cfg_ready
//
// Each accepted start reaches its done strobe through the eleven register stages
// of the date path (two constant dividers of three stages each plus five single
// stages). One date enters every cycle; busy stays low.
// Reset clears the valid bits of every stage and loads the cutover register.
// The result beat cannot be held off, so the pipeline never stalls.
module julian_date_to_calendar #(
    parameter int FRACTION_BITS = 32,
    parameter int DAY_BITS      = 23
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [DAY_BITS+FRACTION_BITS-1:0] julian_date_fixed,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [DAY_BITS-1:0]               cfg_data,
    output logic                              done,
    output logic signed [14:0]                cal_year,
    output logic [3:0]                        cal_month,
    output logic [4:0]                        cal_day,
    output logic [4:0]                        clock_hour,
    output logic [5:0]                        clock_minute,
    output logic [5:0]                        clock_second
);

    localparam int ZW  = DAY_BITS + 1;
    localparam int N1W = DAY_BITS + 3;
    localparam int Q1W = DAY_BITS - 14;
    localparam int BW  = DAY_BITS + 1;
    localparam int N2W = DAY_BITS + 6;
    localparam int CW  = DAY_BITS - 6;
    localparam int DPW = CW + 11;
    localparam int DW  = CW + 9;
    localparam int TPW = FRACTION_BITS + 10;
    localparam int SW  = jdc_pkg::SECS_W;
    localparam int BDW = jdc_pkg::BD_W;

    typedef struct packed {
        logic [ZW-1:0]  z;
        logic           greg;
        logic [TPW-1:0] tprod;
    } s1_side_t;

    // ---------------- configuration ----------------
    logic [DAY_BITS-1:0] cutover_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cutover_reg <= DAY_BITS'(jdc_pkg::CUTOVER_RESET);
        else if (cfg_valid && cfg_ready)
            cutover_reg <= cfg_data;
    end

    // ---------------- stage 1: noon shift, calendar select ----------------
    logic [FRACTION_BITS:0] fsum;
    logic [ZW-1:0]          z_next;
    logic                   greg_next;
    logic [N1W-1:0]         n1_next;
    logic [TPW-1:0]         tprod_next;

    logic                   v1_reg;
    logic [N1W-1:0]         n1_reg;
    s1_side_t               side1_reg;

    assign fsum       = {1'b0, julian_date_fixed[FRACTION_BITS-1:0]}
                      + {2'b01, {(FRACTION_BITS-1){1'b0}}};
    assign z_next     = {1'b0, julian_date_fixed[DAY_BITS+FRACTION_BITS-1:FRACTION_BITS]}
                      + ZW'(fsum[FRACTION_BITS]);
    assign greg_next  = (z_next >= {1'b0, cutover_reg});
    assign n1_next    = {z_next, 2'b00} + N1W'(jdc_pkg::ALPHA_BIAS);
    assign tprod_next = TPW'(fsum[FRACTION_BITS-1:0]) * TPW'(jdc_pkg::SEC_SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        n1_reg          <= n1_next;
        side1_reg.z     <= z_next;
        side1_reg.greg  <= greg_next;
        side1_reg.tprod <= tprod_next;
    end

    // ---------------- alpha divider ----------------
    logic           d1_valid;
    logic [Q1W-1:0] q1;
    s1_side_t       d1_side;

    jdc_cdiv #(
        .N_W     (N1W),
        .DIVISOR (jdc_pkg::ALPHA_DIV),
        .Q_W     (Q1W),
        .SIDE_W  ($bits(s1_side_t))
    ) u_alpha_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1_reg),
        .num       (n1_reg),
        .side_in   (side1_reg),
        .out_valid (d1_valid),
        .quot      (q1),
        .rem       (),
        .side_out  (d1_side)
    );

    // ---------------- stage 2: B, C numerator, seconds of day ----------------
    logic [BW-1:0]  b_next;
    logic [N2W-1:0] n2_next;
    logic [TPW-1:0] trnd;
    logic [SW-1:0]  secs_raw;
    logic [SW-1:0]  secs_next;

    logic           v2_reg;
    logic [N2W-1:0] n2_reg;
    logic [BW-1:0]  b2_reg;
    logic [SW-1:0]  secs2_reg;

    assign b_next = d1_side.greg
                  ? (d1_side.z + BW'(q1 - (q1 >> 2)) + BW'(jdc_pkg::GREG_B_OFFSET))
                  : (d1_side.z + BW'(jdc_pkg::JULIAN_B_OFFSET));
    assign n2_next = N2W'(b_next) * N2W'(jdc_pkg::C_SCALE) - N2W'(jdc_pkg::C_BIAS);

    // Round to nearest second; 86400 folds to 675 << 7
    assign trnd     = d1_side.tprod
                    + (TPW'(1) << (FRACTION_BITS - jdc_pkg::SEC_SCALE_LOG2 - 1));
    assign secs_raw = trnd[FRACTION_BITS+9 : FRACTION_BITS-jdc_pkg::SEC_SCALE_LOG2];
    // Hold a round-up to midnight at the last second of the day
    assign secs_next = (secs_raw > SW'(jdc_pkg::DAY_SECS_MAX))
                     ? SW'(jdc_pkg::DAY_SECS_MAX) : secs_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= d1_valid;
    end

    always_ff @(posedge clk)
    begin
        n2_reg    <= n2_next;
        b2_reg    <= b_next;
        secs2_reg <= secs_next;
    end

    // ---------------- C divider and hour divider, side by side ----------------
    logic          d2_valid;
    logic [CW-1:0] c_q;
    logic [BW-1:0] b_d2;

    jdc_cdiv #(
        .N_W     (N2W),
        .DIVISOR (jdc_pkg::C_DIV),
        .Q_W     (CW),
        .SIDE_W  (BW)
    ) u_c_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .num       (n2_reg),
        .side_in   (b2_reg),
        .out_valid (d2_valid),
        .quot      (c_q),
        .rem       (),
        .side_out  (b_d2)
    );

    logic                       hr_valid;
    logic [jdc_pkg::HOUR_W-1:0] hr_q;
    logic [SW-1:0]              hr_rem;

    jdc_cdiv #(
        .N_W     (SW),
        .DIVISOR (jdc_pkg::SECS_PER_HOUR),
        .Q_W     (jdc_pkg::HOUR_W),
        .SIDE_W  (1)
    ) u_hour_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .num       (secs2_reg),
        .side_in   (1'b0),
        .out_valid (hr_valid),
        .quot      (hr_q),
        .rem       (hr_rem),
        .side_out  ()
    );

    // Minute divider runs alongside the last three date stages
    logic [jdc_pkg::MIN_W-1:0]      mn_q;
    logic [jdc_pkg::HOUR_REM_W-1:0] mn_rem;
    logic [jdc_pkg::HOUR_W-1:0]     hr_out;

    jdc_cdiv #(
        .N_W     (jdc_pkg::HOUR_REM_W),
        .DIVISOR (jdc_pkg::SECS_PER_MIN),
        .Q_W     (jdc_pkg::MIN_W),
        .SIDE_W  (jdc_pkg::HOUR_W)
    ) u_min_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hr_valid),
        .num       (hr_rem[jdc_pkg::HOUR_REM_W-1:0]),
        .side_in   (hr_q),
        .out_valid (),
        .quot      (mn_q),
        .rem       (mn_rem),
        .side_out  (hr_out)
    );

    // ---------------- stage 3: D = floor(1461*C / 4) ----------------
    logic [DPW-1:0] dprod;

    logic           v3_reg;
    logic [CW-1:0]  c3_reg;
    logic [BW-1:0]  b3_reg;
    logic [DW-1:0]  d3_reg;

    assign dprod = DPW'(c_q) * DPW'(jdc_pkg::D_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= d2_valid;
    end

    always_ff @(posedge clk)
    begin
        c3_reg <= c_q;
        b3_reg <= b_d2;
        d3_reg <= dprod[DPW-1:2];
    end

    // ---------------- stage 4: E from the day offset ----------------
    logic [DW-1:0]  bd_full;
    logic [BDW-1:0] bd_next;
    logic [3:0]     e_next;

    logic           v4_reg;
    logic [CW-1:0]  c4_reg;
    logic [BDW-1:0] bd4_reg;
    logic [3:0]     e4_reg;

    // E counts the month bases strictly below the day offset
    always_comb
    begin
        bd_full = DW'(b3_reg) - d3_reg;
        bd_next = bd_full[BDW-1:0];
        e_next  = '0;
        for (int i = 1; i <= jdc_pkg::E_MAX; i++)
        begin
            if (bd_next > jdc_pkg::month_base(4'(i)))
                e_next = e_next + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        c4_reg  <= c3_reg;
        bd4_reg <= bd_next;
        e4_reg  <= e_next;
    end

    // ---------------- stage 5: day, month, year ----------------
    logic [BDW-1:0] day_full;
    logic [3:0]     month_next;
    logic [CW:0]    year_full;

    logic           done_reg;
    logic [14:0]    year_reg;
    logic [3:0]     month_reg;
    logic [4:0]     day_reg;

    assign day_full   = bd4_reg - jdc_pkg::month_base(e4_reg);
    assign month_next = (e4_reg < 4'(jdc_pkg::E_WRAP))
                      ? (e4_reg - 4'(jdc_pkg::E_MONTH_EARLY))
                      : (e4_reg - 4'(jdc_pkg::E_MONTH_LATE));
    assign year_full  = (CW+1)'(c4_reg)
                      - ((month_next > 4'(jdc_pkg::MONTH_FEB))
                         ? (CW+1)'(jdc_pkg::YEAR_BIAS_LATE)
                         : (CW+1)'(jdc_pkg::YEAR_BIAS_EARLY));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        year_reg  <= year_full[14:0];
        month_reg <= month_next;
        day_reg   <= day_full[4:0];
    end

    assign done         = done_reg;
    assign cal_year     = $signed(year_reg);
    assign cal_month    = month_reg;
    assign cal_day      = day_reg;
    assign clock_hour   = hr_out;
    assign clock_minute = mn_q;
    assign clock_second = mn_rem[jdc_pkg::SEC_W-1:0];

endmodule

>>> rtl/core/jdc_cdiv.sv
// Three-stage divider by a constant: reciprocal multiply, back-multiply,
// one correction step. Side data rides along with the valid bit.
module jdc_cdiv #(
    parameter int N_W     = 26,
    parameter int DIVISOR = 146097,
    parameter int Q_W     = 9,
    parameter int SIDE_W  = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [N_W-1:0]    num,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [Q_W-1:0]    quot,
    output logic [N_W-1:0]    rem,
    output logic [SIDE_W-1:0] side_out
);

    localparam int M_W = N_W - $clog2(DIVISOR) + 1;
    localparam int P_W = N_W + M_W;
    localparam logic [M_W-1:0] RECIP = M_W'((64'd1 << N_W) / 64'(DIVISOR));

    logic              va_reg;
    logic              vb_reg;
    logic              vc_reg;
    logic [P_W-1:0]    prod_a_reg;
    logic [N_W-1:0]    num_a_reg;
    logic [SIDE_W-1:0] side_a_reg;
    logic [Q_W-1:0]    qe_b_reg;
    logic [N_W-1:0]    qd_b_reg;
    logic [N_W-1:0]    num_b_reg;
    logic [SIDE_W-1:0] side_b_reg;
    logic [Q_W-1:0]    quot_reg;
    logic [N_W-1:0]    rem_reg;
    logic [SIDE_W-1:0] side_c_reg;

    logic [P_W-1:0]    prod_next;
    logic [Q_W-1:0]    qe_next;
    logic [N_W-1:0]    qd_next;
    logic [N_W-1:0]    diff;
    logic              fix;
    logic [Q_W-1:0]    quot_next;
    logic [N_W-1:0]    rem_next;

    // Estimate is the true quotient or one below it
    assign prod_next = P_W'(num) * P_W'(RECIP);
    assign qe_next   = prod_a_reg[N_W +: Q_W];
    assign qd_next   = N_W'(qe_next) * N_W'(DIVISOR);

    assign diff      = num_b_reg - qd_b_reg;
    assign fix       = (diff >= N_W'(DIVISOR));
    assign quot_next = qe_b_reg + Q_W'(fix);
    assign rem_next  = fix ? (diff - N_W'(DIVISOR)) : diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_a_reg <= prod_next;
        num_a_reg  <= num;
        side_a_reg <= side_in;
        qe_b_reg   <= qe_next;
        num_b_reg  <= num_a_reg;
        side_b_reg <= side_a_reg;
        quot_reg   <= quot_next;
        rem_reg    <= rem_next;
        side_c_reg <= side_b_reg;
    end

    // Back-multiply registered apart from the estimate
    always_ff @(posedge clk)
    begin
        qd_b_reg <= qd_next;
    end

    assign out_valid = vc_reg;
    assign quot      = quot_reg;
    assign rem       = rem_reg;
    assign side_out  = side_c_reg;

endmodule

>>> rtl/core/jdc_chk.sv
module jdc_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [3:0] cal_month,
    input logic [4:0] cal_day,
    input logic [4:0] clock_hour,
    input logic [5:0] clock_minute,
    input logic [5:0] clock_second
);

    // Every accepted date comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(jdc_pkg::LATENCY) done)
        else $error("accepted date did not complete on time");

    // No result without a date accepted the latency before
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, jdc_pkg::LATENCY))
        else $error("result beat with no matching request");

    // The pipeline never pushes back
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cal_month >= 4'd1 && cal_month <= 4'd12
                  && cal_day >= 5'd1 && cal_day <= 5'd31))
        else $error("month or day out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (clock_hour <= 5'd23 && clock_minute <= 6'd59
                  && clock_second <= 6'd59))
        else $error("time of day out of range");

endmodule

bind julian_date_to_calendar jdc_chk u_jdc_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .cal_month    (cal_month),
    .cal_day      (cal_day),
    .clock_hour   (clock_hour),
    .clock_minute (clock_minute),
    .clock_second (clock_second)
);

>>> tb/sv/julian_date_to_calendar_tb.sv
`timescale 1ns / 100ps

typedef struct packed {
    logic [14:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
} calendar_t;

class calendar_scoreboard;
    logic [22:0] cutover;
    calendar_t   pending_dates[$];
    int          dates_in;
    int          results_seen;
    int          errors;

    function new();
        cutover      = 23'(jdc_pkg::CUTOVER_RESET);
        dates_in     = 0;
        results_seen = 0;
        errors       = 0;
    endfunction

    function longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if (n % d != 0 && n < 0)
        begin
            q = q - 1;
        end
        return q;
    endfunction

    // Meeus conversion with every step as an exact floor division
    function calendar_t convert(logic [54:0] jd);
        logic [32:0] half_sum;
        logic [23:0] day_num;
        longint      z, alpha, a, b, c, d, e, mday, month, year, secs;
        calendar_t   r;
        // the date turns over at noon: add half a day before splitting
        half_sum = {1'b0, jd[31:0]} + 33'h0_8000_0000;
        day_num  = {1'b0, jd[54:32]} + 24'(half_sum[32]);
        z = longint'(day_num);
        if (day_num < {1'b0, cutover})
        begin
            a = z;
        end
        else
        begin
            alpha = floor_quot(4 * z - 7468865, 146097);
            a     = z + 1 + alpha - floor_quot(alpha, 4);
        end
        b     = a + 1524;
        c     = floor_quot(20 * b - 2442, 7305);
        d     = floor_quot(1461 * c, 4);
        e     = floor_quot(10000 * (b - d), 306001);
        mday  = b - d - floor_quot(306001 * e, 10000);
        month = (e < 14) ? e - 1 : e - 13;
        year  = (month > 2) ? c - 4716 : c - 4715;
        secs  = (longint'(half_sum[31:0]) * 86400 + 64'sh8000_0000) >>> 32;
        // hold a round-up to midnight on the same date
        if (secs > 86399)
        begin
            secs = 86399;
        end
        r.year   = year[14:0];
        r.month  = month[3:0];
        r.day    = mday[4:0];
        r.hour   = 5'(secs / 3600);
        r.minute = 6'((secs % 3600) / 60);
        r.second = 6'(secs % 60);
        return r;
    endfunction

    function void note_date(logic [54:0] jd);
        pending_dates.insert(pending_dates.size(), convert(jd));
        dates_in++;
    endfunction

    function void field_check(string name, logic signed [15:0] want,
                              logic signed [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function void check_result(calendar_t got);
        calendar_t want;
        if (pending_dates.size() == 0)
        begin
            errors++;
            $display("%0t ns: result beat with no date pending, got %0d-%0d-%0d %0d:%0d:%0d",
                     $time, $signed(got.year), got.month, got.day,
                     got.hour, got.minute, got.second);
        end
        else
        begin
            want = pending_dates.pop_front();
            results_seen++;
            field_check("cal_year", $signed(want.year), $signed(got.year));
            field_check("cal_month", want.month, got.month);
            field_check("cal_day", want.day, got.day);
            field_check("clock_hour", want.hour, got.hour);
            field_check("clock_minute", want.minute, got.minute);
            field_check("clock_second", want.second, got.second);
        end
    endfunction
endclass

module julian_date_to_calendar_tb;

    localparam int FRAC_W            = 32;
    localparam int DAY_W             = 23;
    localparam int QUIET_LIMIT       = 2000;
    localparam int HISTORIC_LAST_DAY = 5373484;
    localparam logic [31:0] HALF_DAY = 32'h8000_0000;
    // a day fraction worth just under half a second
    localparam logic [31:0] HALF_SEC = 32'd24855;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [DAY_W+FRAC_W-1:0]   julian_date_fixed;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [DAY_W-1:0]          cfg_data;
    logic                      done;
    logic signed [14:0]        cal_year;
    logic [3:0]                cal_month;
    logic [4:0]                cal_day;
    logic [4:0]                clock_hour;
    logic [5:0]                clock_minute;
    logic [5:0]                clock_second;

    calendar_scoreboard sb;
    int                 quiet_cycles;
    int                 cutover_settings;

    julian_date_to_calendar #(
        .FRACTION_BITS (FRAC_W),
        .DAY_BITS      (DAY_W)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .julian_date_fixed (julian_date_fixed),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .done              (done),
        .cal_year          (cal_year),
        .cal_month         (cal_month),
        .cal_day           (cal_day),
        .clock_hour        (clock_hour),
        .clock_minute      (clock_minute),
        .clock_second      (clock_second)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // every strobed cycle is a result beat; an X strobe counts as one too
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done !== 1'b0)
        begin
            sb.check_result({cal_year, cal_month, cal_day,
                             clock_hour, clock_minute, clock_second});
        end
    end

    function logic [54:0] make_jd(logic [22:0] z, logic [31:0] f);
        return {z, f};
    endfunction

    function logic [54:0] random_jd();
        logic [63:0] wide;
        logic [22:0] z;
        logic [31:0] f;
        int          pick;
        wide = {$urandom, $urandom};
        f    = $urandom;
        pick = $urandom_range(9);
        case (pick)
            0, 1, 2, 3: return wide[54:0];
            4, 5, 6:    z = 23'($urandom_range(HISTORIC_LAST_DAY));
            7:          z = sb.cutover + 23'($urandom_range(6)) - 23'd3;
            8:
            begin
                z = 23'($urandom_range(HISTORIC_LAST_DAY));
                // land near midnight or near a half-second rounding step
                if ($urandom_range(1) == 1)
                begin
                    f = HALF_DAY - 32'd1 - 32'($urandom_range(3 * HALF_SEC));
                end
                else
                begin
                    f = HALF_DAY + 32'($urandom_range(3 * HALF_SEC));
                end
            end
            default:    z = 23'($urandom_range(800000));
        endcase
        return make_jd(z, f);
    endfunction

    task automatic drive_date(input logic [54:0] jd);
        start             <= 1'b1;
        julian_date_fixed <= jd;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        sb.note_date(jd);
    endtask

    task automatic idle_some();
        int gap;
        gap = 0;
        while ($urandom_range(99) < 27)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            start             <= 1'b0;
            julian_date_fixed <= 55'({$urandom, $urandom});
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_random(input int count, input bit steady);
        repeat (count)
        begin
            if (!steady)
            begin
                idle_some();
            end
            drive_date(random_jd());
        end
    endtask

    // hold off until every pending date has come back, then let the pipe settle
    task automatic drain_results();
        start <= 1'b0;
        while (sb.pending_dates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (jdc_pkg::LATENCY) @(posedge clk);
    endtask

    task automatic write_cutover(input logic [22:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (cfg_ready !== 1'b1);
        cfg_valid  <= 1'b0;
        sb.cutover = value;
        cutover_settings++;
    endtask

    // range ends and both sides of the calendar switch under the current cutover
    task automatic edge_dates();
        drive_date(make_jd(23'd0, 32'd0));
        drive_date({55{1'b1}});
        drive_date(make_jd(sb.cutover - 23'd1, 32'd0));
        drive_date(make_jd(sb.cutover, 32'd0));
        drive_date(make_jd(sb.cutover - 23'd1, HALF_DAY));
    endtask

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((start === 1'b1 && busy === 1'b0) || done === 1'b1 ||
                (cfg_valid === 1'b1 && cfg_ready === 1'b1))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("%0t ns: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        sb                = new();
        cutover_settings  = 1;
        rst_n             = 1'b0;
        start             = 1'b0;
        julian_date_fixed = '0;
        cfg_valid         = 1'b0;
        cfg_data          = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset cutover: range ends, rounding, calendar switch, known dates
        drive_date(make_jd(23'd0, 32'd0));
        drive_date({55{1'b1}});
        drive_date(make_jd(23'd0, HALF_DAY - 32'd1));
        drive_date(make_jd(23'd0, HALF_DAY));
        drive_date(make_jd(23'd2299160, 32'd0));
        drive_date(make_jd(23'd2299161, 32'd0));
        drive_date(make_jd(23'd2299160, HALF_DAY));
        drive_date(make_jd(23'd2451545, 32'd0));
        drive_date(make_jd(23'd2451545, HALF_DAY + HALF_SEC));
        drive_date(make_jd(23'd2451545, HALF_DAY + HALF_SEC + 32'd1));
        drive_date(make_jd(23'd2451603, HALF_DAY));
        drive_date(make_jd(23'd2451604, HALF_DAY));
        drive_date(make_jd(23'd2415078, HALF_DAY));
        drive_date(make_jd(23'd2415079, HALF_DAY));
        drive_date(make_jd(23'd1000000, 32'd1));
        drive_date(make_jd(23'd1000000, 32'hFFFF_FFFF));
        drive_date(make_jd(23'(HISTORIC_LAST_DAY), HALF_DAY - 32'd1));
        drive_date(make_jd(23'h7F_FFFF, 32'd0));
        drive_date(make_jd(23'h2A_AAAA, 32'h5555_5555));
        drive_date(make_jd(23'h55_5555, 32'hAAAA_AAAA));
        run_random(55, 1'b0);
        drain_results();
        run_random(55, 1'b0);

        drain_results();
        write_cutover(23'd0);
        edge_dates();
        run_random(70, 1'b1);
        run_random(40, 1'b0);

        drain_results();
        write_cutover(23'h7F_FFFF);
        edge_dates();
        run_random(80, 1'b0);

        drain_results();
        write_cutover(23'($urandom_range(1, 8388606)));
        edge_dates();
        run_random(60, 1'b0);

        drain_results();
        write_cutover(23'(jdc_pkg::CUTOVER_RESET));
        run_random(60, 1'b0);

        drain_results();
        repeat (jdc_pkg::LATENCY) @(posedge clk);

        $display("Converted %0d dates under %0d cutover settings, including range ends,",
                 sb.dates_in, cutover_settings);
        $display("midnight rounding and calendar switch edges; %0d results, %0d mismatches",
                 sb.results_seen, sb.errors);
        if (sb.errors == 0 && sb.pending_dates.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
